@@ sv/hpq_pkg.sv @@
// shared constants and codes for the binary heap priority queue
// no dependencies
package hpq_pkg;
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int IN_W       = ((2 + DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_W      = ((2 + DATA_WIDTH + CW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;
endpackage

@@ sv/hpq_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module hpq_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ sv/binary_heap_priority_queue.sv @@
// top level of the binary heap priority queue: sequencer around one heap ram
// depends on hpq_pkg and hpq_ram
//
//  channel  dir  handshake                tdata / data fields (low bit up)
//  in_      in   in_tvalid / in_tready    operation[1:0], value[33:2], zero pad
//  out_     out  out_tvalid / out_tready  status[1:0], result_value[33:2],
//                                         count[40:34], zero pad
//  cfg_     in   cfg_we                   cfg_wdata[0] = max_mode
//
// one item at a time; a peek reads only the root, and a failed insert goes straight to the done state
// insert, delete and pop rebuild the whole heap bottom-up: each node is read with its
// two children, and a swap writes both entries before it sifts on down
// delete scans the ram one entry per cycle before the rebuild
// all cost comes from the single ram port, one access per cycle
// reset is synchronous; a stalled result holds in
// the output register and the sequencer waits in its done state
module binary_heap_priority_queue
  import hpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // operation, value
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, result_value, count
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ROOT, S_LAST, S_REB,
    S_SDN, S_SDL, S_SDR, S_SDW, S_SDS, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   mode_r;
  op_t                    op_r, op_nxt;
  logic [DATA_WIDTH-1:0]  val_r, val_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          rb_r, rb_nxt;
  logic [AW-1:0]          node_r, node_nxt;
  logic [AW-1:0]          best_r, best_nxt;
  logic [DATA_WIDTH-1:0]  nv_r, nv_nxt;
  logic [DATA_WIDTH-1:0]  lv_r, lv_nxt;
  status_t                st_r, st_nxt;
  logic [DATA_WIDTH-1:0]  res_r, res_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]       out_tdata_r, out_tdata_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [DATA_WIDTH-1:0]  ram_wd, ram_rd;

  op_t                    in_op;
  logic [DATA_WIDTH-1:0]  in_val;
  logic [AW+1:0]          left_w, right_w;
  logic                   lvalid, rvalid;
  logic [AW-1:0]          sel_idx;
  logic [DATA_WIDTH-1:0]  sel_val;
  logic [CW-1:0]          cnt_m1;
  logic [AW-1:0]          rb_start;

  function automatic logic above(input logic m, input logic [DATA_WIDTH-1:0] a,
                                 input logic [DATA_WIDTH-1:0] b);
    above = m ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

  hpq_ram #(.W(DATA_WIDTH), .D(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  assign in_op    = op_t'(in_tdata[1:0]);
  assign in_val   = in_tdata[DATA_WIDTH+1:2];
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // children of the current node, two bits wider than an address so the compare cannot wrap
  assign left_w  = {1'b0, node_r, 1'b1};
  assign right_w = left_w + (AW+2)'(1);
  assign lvalid  = left_w < (AW+2)'(cnt_r);
  assign rvalid  = right_w < (AW+2)'(cnt_r);
  assign cnt_m1  = cnt_r - CW'(1);
  assign rb_start = cnt_m1[AW:1];

  // pick the child that should sit above the node, if any
  always_comb begin
    sel_idx = node_r;
    sel_val = nv_r;
    if (lvalid && above(mode_r, lv_r, sel_val)) begin
      sel_idx = left_w[AW-1:0];
      sel_val = lv_r;
    end
    if (rvalid && above(mode_r, ram_rd, sel_val)) begin
      sel_idx = right_w[AW-1:0];
      sel_val = ram_rd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    rb_nxt    = rb_r;
    node_nxt  = node_r;
    best_nxt  = best_r;
    nv_nxt    = nv_r;
    lv_nxt    = lv_r;
    st_nxt    = st_r;
    res_nxt   = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wd    = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_op;
          val_nxt = in_val;
          res_nxt = in_val;
          st_nxt  = ST_OK;
          idx_nxt = '0;
          case (in_op)
            OP_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = cnt_r[AW-1:0];
                ram_wd    = in_val;
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_REB;
              end
            end
            OP_DELETE: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_NOTFOUND;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                res_nxt   = '0;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_ROOT;
              end
            end
          endcase
        end
      end
      // compare entry idx while fetching the next one
      S_SCAN: begin
        if (ram_rd == val_r) begin
          ram_addr  = cnt_m1[AW-1:0];
          state_nxt = S_LAST;
        end else if (CW'(idx_r) + CW'(1) == cnt_r) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          ram_addr  = idx_r + AW'(1);
        end
      end
      S_ROOT: begin
        res_nxt = ram_rd;
        if (op_r == OP_POP) begin
          ram_addr  = cnt_m1[AW-1:0];
          state_nxt = S_LAST;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // last entry moves into the freed slot
      S_LAST: begin
        ram_we    = 1'b1;
        ram_addr  = idx_r;
        ram_wd    = ram_rd;
        cnt_nxt   = cnt_m1;
        state_nxt = S_REB;
      end
      S_REB: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          rb_nxt    = rb_start;
          node_nxt  = rb_start;
          ram_addr  = rb_start;
          state_nxt = S_SDN;
        end
      end
      S_SDN: begin
        nv_nxt    = ram_rd;
        ram_addr  = left_w[AW-1:0];
        state_nxt = S_SDL;
      end
      S_SDL: begin
        lv_nxt    = ram_rd;
        ram_addr  = right_w[AW-1:0];
        state_nxt = S_SDR;
      end
      S_SDR: begin
        if (sel_idx != node_r) begin
          ram_we    = 1'b1;
          ram_addr  = node_r;
          ram_wd    = sel_val;
          best_nxt  = sel_idx;
          state_nxt = S_SDW;
        end else if (rb_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          rb_nxt    = rb_r - AW'(1);
          node_nxt  = rb_r - AW'(1);
          ram_addr  = rb_r - AW'(1);
          state_nxt = S_SDN;
        end
      end
      S_SDW: begin
        ram_we    = 1'b1;
        ram_addr  = best_r;
        ram_wd    = nv_r;
        node_nxt  = best_r;
        state_nxt = S_SDS;
      end
      // node value is still nv, fetch its new left child
      S_SDS: begin
        ram_addr  = left_w[AW-1:0];
        state_nxt = S_SDL;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_W'({cnt_r, res_r, st_r});
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      mode_r       <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    rb_r        <= rb_nxt;
    node_r      <= node_nxt;
    best_r      <= best_nxt;
    nv_r        <= nv_nxt;
    lv_r        <= lv_nxt;
    st_r        <= st_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // item count never passes the store size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("item count above depth");

  // a full report leaves a full store
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && st_r == ST_FULL) |-> cnt_r == CW'(DEPTH))
    else $error("full status with room left");

  // an empty report comes with zero count and zero value
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && st_r == ST_EMPTY) |-> (cnt_r == '0 && res_r == '0))
    else $error("empty status on a non-empty store");
endmodule

@@ verif/binary_heap_priority_queue_tb.sv @@
// self-checking testbench for the binary heap priority queue
// depends on hpq_pkg and the binary_heap_priority_queue rtl
// a behavioral heap predicts every result beat, checked in arrival order
module binary_heap_priority_queue_tb;
  import hpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [6:0]  count;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  binary_heap_priority_queue uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // predictor state: heap contents, fill level and order
  logic [31:0] heap_mem [DEPTH];
  int unsigned heap_fill;
  logic        order_max;

  request_t  pending_reqs [$];
  response_t awaited_results [$];
  int        error_count = 0;
  bit        sender_idle_on = 1'b1;
  bit        receiver_idle_on = 1'b1;
  int        hold_off_cycles = 0;

  // true when a belongs above b under the current order
  function automatic bit ranks_above(logic [31:0] a, logic [31:0] b);
    if (order_max) return $signed(a) > $signed(b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void sift_node(int unsigned start);
    int unsigned node, lc, rc, best;
    logic [31:0] t;
    node = start;
    while (node < heap_fill) begin
      lc = 2 * node + 1;
      rc = 2 * node + 2;
      best = node;
      if (lc < heap_fill && ranks_above(heap_mem[lc], heap_mem[best])) best = lc;
      if (rc < heap_fill && ranks_above(heap_mem[rc], heap_mem[best])) best = rc;
      if (best == node) break;
      t = heap_mem[node];
      heap_mem[node] = heap_mem[best];
      heap_mem[best] = t;
      node = best;
    end
  endfunction

  // full bottom-up heapify after every change of the store
  function automatic void heapify_all();
    int i;
    if (heap_fill == 0) return;
    for (i = (heap_fill - 1) / 2; i >= 0; i--) sift_node(i);
  endfunction

  function automatic bit remove_first_copy(logic [31:0] v);
    for (int unsigned i = 0; i < heap_fill; i++) begin
      if (heap_mem[i] == v) begin
        heap_mem[i] = heap_mem[heap_fill - 1];
        heap_fill--;
        heapify_all();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic response_t predict_heap_op(request_t r);
    response_t res;
    res.status = ST_OK;
    res.value = r.value;
    case (r.op)
      OP_INSERT: begin
        if (heap_fill >= DEPTH) res.status = ST_FULL;
        else begin
          heap_mem[heap_fill] = r.value;
          heap_fill++;
          heapify_all();
        end
      end
      OP_DELETE: begin
        if (!remove_first_copy(r.value)) res.status = ST_NOTFOUND;
      end
      default: begin
        if (heap_fill == 0) begin
          res.status = ST_EMPTY;
          res.value = '0;
        end else begin
          res.value = heap_mem[0];
          if (r.op == OP_POP) void'(remove_first_copy(heap_mem[0]));
        end
      end
    endcase
    res.count = heap_fill[6:0];
    return res;
  endfunction

  // driver: presents queued requests, ~10% idle gaps when enabled
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) awaited_results.push_back(predict_heap_op(pending_reqs.pop_front()));
        if (pending_reqs.size() > (in_tvalid ? 0 : 0) &&
            !(sender_idle_on && $urandom_range(0, 99) < 10)) begin
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_W - 34){1'b0}}, pending_reqs[0].value, pending_reqs[0].op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, long hold-off on request, beat checks
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        response_t got, want;
        got.status = status_t'(out_tdata[1:0]);
        got.value = out_tdata[33:2];
        got.count = out_tdata[40:34];
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got.value !== want.value)
            $display("%0t: value exp %h got %h", $time, want.value, got.value);
          if (got.count !== want.count)
            $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
          if (got !== want) error_count++;
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(receiver_idle_on && $urandom_range(0, 99) < 10);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_fffc + $urandom_range(0, 3);
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(op_t op, logic [31:0] v);
    request_t r;
    r.op = op;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  // wait until every queued request is in and every result checked
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_order(bit max_first);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= max_first;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_max = max_first;
  endtask

  // random phase; fill_bias is the percentage of inserts, a high one fills the store
  task automatic random_phase(int n, int fill_bias);
    logic [31:0] recent [$];
    for (int i = 0; i < n; i++) begin
      int sel;
      logic [31:0] v;
      sel = $urandom_range(0, 99);
      v = pick_value();
      if (sel < fill_bias) begin
        queue_req(OP_INSERT, v);
        recent.push_back(v);
      end else if (sel < fill_bias + 15) begin
        // mostly delete values known to have been inserted
        if (recent.size() != 0 && $urandom_range(0, 3) != 0)
          v = recent[$urandom_range(0, recent.size() - 1)];
        queue_req(OP_DELETE, v);
      end else if (sel < fill_bias + 25) queue_req(OP_PEEK, v);
      else queue_req(OP_POP, v);
    end
  endtask

  initial begin
    heap_fill = 0;
    order_max = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, extremes, duplicates, every operation
    queue_req(OP_PEEK, 32'h1234_5678);
    queue_req(OP_POP, 32'hffff_ffff);
    queue_req(OP_DELETE, 32'd5);
    queue_req(OP_INSERT, 32'h8000_0000);
    queue_req(OP_INSERT, 32'h7fff_ffff);
    queue_req(OP_INSERT, 32'h0000_0000);
    queue_req(OP_INSERT, 32'hffff_ffff);
    queue_req(OP_INSERT, 32'h7fff_ffff);
    queue_req(OP_PEEK, 32'h0);
    queue_req(OP_DELETE, 32'h7fff_ffff);
    queue_req(OP_DELETE, 32'h1111_1111);
    queue_req(OP_POP, 32'h0);
    queue_req(OP_PEEK, 32'h0);
    drain();
    // mode change: peek sees the old root until the next rebuild
    set_order(1'b0);
    queue_req(OP_PEEK, 32'h0);
    queue_req(OP_INSERT, 32'h0000_0001);
    queue_req(OP_POP, 32'h0);
    queue_req(OP_POP, 32'h0);
    queue_req(OP_POP, 32'h0);
    queue_req(OP_POP, 32'h0);
    queue_req(OP_POP, 32'h0);
    drain();

    // fill past full while the receiver holds off, so the input stalls
    hold_off_cycles = 3000;
    for (int i = 0; i < 70; i++) queue_req(OP_INSERT, pick_value());
    queue_req(OP_DELETE, 32'h4444_4444);
    drain();
    // sender paused until all results came; now empty it in max order
    set_order(1'b1);
    queue_req(OP_INSERT, 32'h0);
    for (int i = 0; i < 68; i++) queue_req(OP_POP, 32'h0);
    drain();

    random_phase(200, 50);
    drain();
    set_order(1'b0);
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    random_phase(200, 60);
    drain();
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    set_order(1'b1);
    random_phase(60, 45);
    drain();
    set_order(1'b0);
    random_phase(80, 35);
    drain();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/hpq_pkg.sv
sv/hpq_ram.sv
sv/binary_heap_priority_queue.sv
verif/binary_heap_priority_queue_tb.sv
